>>> rtl/apu_pkg.sv
// Package for the alpha premultiply unit: payload structs, register codes,
// widths and the maximum sample value helper.
// Depends on nothing; every file of the unit imports it.
package apu_pkg;

    localparam int DATA_W          = 16;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int NUM_COLORS      = 3;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_DEPTH = 1'b1;

    localparam logic [CFG_DATA_W-1:0] BIT_DEPTH_MIN   = 5'd8;
    localparam logic [CFG_DATA_W-1:0] BIT_DEPTH_RESET = 5'd8;

    // Restoring divider layout: one quotient bit per step.
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = DATA_W / DIV_BITS_PER_STAGE;

    typedef struct packed {
        logic [DATA_W-1:0] red_in;
        logic [DATA_W-1:0] green_in;
        logic [DATA_W-1:0] blue_in;
        logic [DATA_W-1:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] red_out;
        logic [DATA_W-1:0] green_out;
        logic [DATA_W-1:0] blue_out;
        logic [DATA_W-1:0] alpha_out;
    } pixel_out_t;

    // Per-color state of the divider.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] quo;
        logic              sat;
    } div_lane_t;

    // Per-pixel values that travel alongside the color lanes.
    typedef struct packed {
        logic [DATA_W-1:0] alpha;
        logic [DATA_W-1:0] divisor;
        logic [DATA_W-1:0] maxv;
        logic              zero;
    } pix_ctx_t;

    // Maximum sample value for a bit depth, with the depth clamped to the
    // range from eight bits up to the sample width.
    function automatic logic [DATA_W-1:0] sample_max(
        input logic [CFG_DATA_W-1:0] bit_depth,
        input logic [CFG_DATA_W-1:0] sample_width
    );
        logic [CFG_DATA_W-1:0] bd;
        logic [DATA_W:0]       one_hot;
        bd = bit_depth;
        if (bd < BIT_DEPTH_MIN) begin
            bd = BIT_DEPTH_MIN;
        end
        if (bd > sample_width) begin
            bd = sample_width;
        end
        one_hot = (DATA_W + 1)'(1) << bd;
        return DATA_W'(one_hot - (DATA_W + 1)'(1));
    endfunction

endpackage

>>> rtl/alpha_premultiply_unit.sv
// Alpha premultiply / unpremultiply unit: top level with the full pipeline.
// Depends on apu_pkg (payload structs, register codes, sample_max).
//
// Pipeline: the input transfer edge itself loads the first of the seven register
// stages, and the result on m_data comes from the last one.
// Throughput: one pixel per cycle while m_ready does not stall the output stage.
// Reset: aresetn (synchronous, active low) empties the pipeline, sets
// direction to premultiply and bit depth to 8.
module alpha_premultiply_unit #(
    parameter int SAMPLE_WIDTH = apu_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [apu_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [apu_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // Input pixel channel.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  apu_pkg::pixel_in_t               s_data,
    // Result pixel channel.
    output logic                             m_valid,
    input  logic                             m_ready,
    output apu_pkg::pixel_out_t              m_data
);
    import apu_pkg::*;

    // Both operations reduce to one form: color * mult / divisor.
    // Premultiply uses mult = alpha and divisor = max; unpremultiply uses
    // mult = max and divisor = alpha. The same restoring divider then serves
    // both directions. The stages are:
    //   stage 0           16x16 multiply per color, operand selection
    //   stage 1           overflow check, divider setup
    //   stages 2 .. 5     four quotient bits per stage
    //   stage 6           saturation and the output register
    localparam int NSTG   = DIV_STAGES + 3;
    localparam int S_MUL  = 0;
    localparam int S_INIT = 1;
    localparam int S_OUT  = NSTG - 1;
    localparam logic [CFG_DATA_W-1:0] SW5 = CFG_DATA_W'(SAMPLE_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers. The maximum sample value is computed at
    // the write so that no shift sits in front of the multipliers.
    // ------------------------------------------------------------------
    logic              direction_reg;
    logic [DATA_W-1:0] maxv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
            maxv_reg      <= sample_max(BIT_DEPTH_RESET, SW5);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DIRECTION: direction_reg <= cfg_wr_data[0];
                REG_BIT_DEPTH: maxv_reg      <= sample_max(cfg_wr_data, SW5);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage loads when it is empty or when the stage
    // after it is loading, so bubbles close up and a stalled output still
    // lets earlier stages fill.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   adv;

    assign adv[NSTG] = m_ready;

    for (genvar i = 0; i < NSTG; i++) begin : g_flow
        assign adv[i] = !vld_reg[i] || adv[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (adv[i]) begin
                vld_reg[i] <= (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[S_OUT];

    // Context registers for stages 0 .. NSTG-2; the output stage keeps only
    // the finished pixel.
    pix_ctx_t ctx_reg [NSTG-1];

    // ------------------------------------------------------------------
    // Stage 0: operand selection and one multiplier per color.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] color_in [NUM_COLORS];
    logic [DATA_W-1:0] mult_op;
    pix_ctx_t          ctx_next;
    logic [PROD_W-1:0] prod_reg [NUM_COLORS];

    assign color_in[0] = s_data.red_in;
    assign color_in[1] = s_data.green_in;
    assign color_in[2] = s_data.blue_in;

    always_comb begin
        ctx_next.alpha   = s_data.alpha_in;
        ctx_next.maxv    = maxv_reg;
        ctx_next.divisor = direction_reg ? s_data.alpha_in : maxv_reg;
        ctx_next.zero    = direction_reg && (s_data.alpha_in == '0);
        mult_op          = direction_reg ? maxv_reg : s_data.alpha_in;
    end

    always_ff @(posedge aclk) begin
        if (adv[S_MUL]) begin
            ctx_reg[S_MUL] <= ctx_next;
            for (int c = 0; c < NUM_COLORS; c++) begin
                prod_reg[c] <= PROD_W'(color_in[c]) * PROD_W'(mult_op);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: a quotient of 2^16 or more is caught here, so the divider
    // only has to produce sixteen bits. The upper product half is already
    // below the divisor when there is no overflow.
    // ------------------------------------------------------------------
    div_lane_t init_reg [NUM_COLORS];

    always_ff @(posedge aclk) begin
        if (adv[S_INIT]) begin
            ctx_reg[S_INIT] <= ctx_reg[S_MUL];
            for (int c = 0; c < NUM_COLORS; c++) begin
                init_reg[c].rem <= prod_reg[c][PROD_W-1:DATA_W];
                init_reg[c].num <= prod_reg[c][DATA_W-1:0];
                init_reg[c].quo <= '0;
                init_reg[c].sat <= prod_reg[c][PROD_W-1:DATA_W] >= ctx_reg[S_MUL].divisor;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 .. 5: restoring division, four bits per stage.
    // ------------------------------------------------------------------
    function automatic div_lane_t div_step(input div_lane_t l, input logic [DATA_W-1:0] d);
        logic [DATA_W:0] t;
        logic [DATA_W:0] diff;
        div_lane_t       r;
        r     = l;
        t     = {l.rem, l.num[DATA_W-1]};
        diff  = t - {1'b0, d};
        r.num = {l.num[DATA_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            r.rem = diff[DATA_W-1:0];
            r.quo = {l.quo[DATA_W-2:0], 1'b1};
        end else begin
            r.rem = t[DATA_W-1:0];
            r.quo = {l.quo[DATA_W-2:0], 1'b0};
        end
        return r;
    endfunction

    div_lane_t div_reg [DIV_STAGES][NUM_COLORS];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        div_lane_t lane_in   [NUM_COLORS];
        div_lane_t lane_next [NUM_COLORS];

        for (genvar c = 0; c < NUM_COLORS; c++) begin : g_lane
            if (k == 0) begin : g_first
                assign lane_in[c] = init_reg[c];
            end else begin : g_rest
                assign lane_in[c] = div_reg[k-1][c];
            end

            always_comb begin
                lane_next[c] = lane_in[c];
                for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                    lane_next[c] = div_step(lane_next[c], ctx_reg[S_INIT+k].divisor);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[S_INIT+1+k]) begin
                for (int c = 0; c < NUM_COLORS; c++) begin
                    div_reg[k][c] <= lane_next[c];
                end
                if (S_INIT + 1 + k < S_OUT) begin
                    ctx_reg[(S_INIT+1+k < S_OUT) ? S_INIT+1+k : 0] <= ctx_reg[S_INIT+k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: saturate at max, force zero for a zero alpha when dividing,
    // and hold the result until it is taken.
    // ------------------------------------------------------------------
    pix_ctx_t          last_ctx;
    logic [DATA_W-1:0] color_next [NUM_COLORS];
    pixel_out_t        out_reg;

    assign last_ctx = ctx_reg[S_OUT-1];

    always_comb begin
        for (int c = 0; c < NUM_COLORS; c++) begin
            if (last_ctx.zero) begin
                color_next[c] = '0;
            end else if (div_reg[DIV_STAGES-1][c].sat ||
                         (div_reg[DIV_STAGES-1][c].quo > last_ctx.maxv)) begin
                color_next[c] = last_ctx.maxv;
            end else begin
                color_next[c] = div_reg[DIV_STAGES-1][c].quo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[S_OUT]) begin
            out_reg.red_out   <= color_next[0];
            out_reg.green_out <= color_next[1];
            out_reg.blue_out  <= color_next[2];
            out_reg.alpha_out <= last_ctx.alpha;
        end
    end

    assign m_data = out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An empty pipeline always takes a transfer.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg == '0) |-> s_ready)
        else $error("pipeline empty but s_ready low");

    // Pixels in flight change only by the transfers on the two channels.
    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ($countones(vld_reg) == $past($countones(vld_reg))
                  + int'($past(s_valid && s_ready))
                  - int'($past(m_valid && m_ready))))
        else $error("pixel lost or duplicated inside the pipeline");

    // Results never exceed the maximum sample value.
    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.red_out <= maxv_reg) && (m_data.green_out <= maxv_reg)
                    && (m_data.blue_out <= maxv_reg))
        else $error("color result above maximum sample value");

endmodule
